// ===== hdl/tcs_pkg.sv =====
// shared widths, register indexes and divider types for the texture column scaler
`default_nettype none
package tcs_pkg;

	localparam int TEXEL_W  = 32;
	localparam int ADDR_W   = 16;
	localparam int SIDE_W   = 7;
	localparam int TOTAL_W  = 5;
	localparam int TILE_W   = 4;
	localparam int COL_W    = 6;
	localparam int ROW_W    = 12;
	localparam int HEIGHT_W = 13;

	localparam int MAX_TILE_SIDE     = 64;
	localparam int MAX_TILES         = 16;
	localparam int MAX_COLUMN_HEIGHT = 4096;

	// source row is below tile_side, so it never needs more bits than tile_side
	localparam int QUOT_W     = SIDE_W;
	localparam int DIVIDEND_W = ROW_W + SIDE_W;
	localparam int CNT_W      = $clog2(QUOT_W);

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = SIDE_W;

	localparam logic [CFG_IDX_W-1:0] REG_TILE_SIDE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TILE_TOTAL = 1'b1;

	localparam logic [SIDE_W-1:0]   TILE_SIDE_RESET  = SIDE_W'(64);
	localparam logic [TOTAL_W-1:0]  TILE_TOTAL_RESET = TOTAL_W'(1);
	localparam logic [SIDE_W-1:0]   MAX_SIDE_V       = SIDE_W'(MAX_TILE_SIDE);
	localparam logic [TOTAL_W-1:0]  MAX_TOTAL_V      = TOTAL_W'(MAX_TILES);
	localparam logic [HEIGHT_W-1:0] MAX_HEIGHT_V     = HEIGHT_W'(MAX_COLUMN_HEIGHT);

	localparam logic MODE_WRITE  = 1'b0;
	localparam logic MODE_SAMPLE = 1'b1;

	typedef struct packed {
		logic                done;
		logic [QUOT_W-1:0]   quotient;
	} div_res_t;

endpackage
`default_nettype wire

// ===== hdl/texture_column_scaler.sv =====
// top level: texel store, request checks, address arithmetic and sequencing
`default_nettype none
// Texel store of 65536 x 32 bits holding square tiles packed side by side, row-major.
// Command channel: an item is taken at a clock edge with start high and busy low.
// mode 0 writes store_value at store_address; busy stays low and no result
// follows. mode 1 samples one texel of a nearest-neighbour scaled
// column; exactly one result follows, shown for one cycle with done high.
// A sample with a bad tile, column, row or size gives done in the cycle after
// acceptance with texel 0 and range_error set, and busy stays low.
// A good sample keeps busy high through its steps in order: the multiplies, the
// bit-serial divider for the source row, picking up the quotient to form the row
// offset, then the store read. done rises as busy falls, and the next item can be
// taken while done is high, so good samples are taken one at a time; the divider
// sets the throughput.
// Results cannot be held off: whoever listens must take done when it comes.
// Configuration (tile_side, tile_total) is to be written through cfg_write only while
// idle; the block does not enforce this. Reset sets tile_side to 64 and tile_total to 1
// and leaves the store contents undefined until written; no clearing pass is run.
module texture_column_scaler (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_write,
	input  wire logic [tcs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tcs_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           start,
	output      logic                           busy,
	input  wire logic                           mode,
	input  wire logic [tcs_pkg::ADDR_W-1:0]     store_address,
	input  wire logic [tcs_pkg::TEXEL_W-1:0]    store_value,
	input  wire logic [tcs_pkg::TILE_W-1:0]     tile_number,
	input  wire logic [tcs_pkg::COL_W-1:0]      tile_column,
	input  wire logic [tcs_pkg::ROW_W-1:0]      output_row,
	input  wire logic [tcs_pkg::HEIGHT_W-1:0]   scaled_height,
	output      logic                           done,
	output      logic [tcs_pkg::TEXEL_W-1:0]    texel,
	output      logic                           range_error
);
	import tcs_pkg::*;

	localparam int IMGW_W   = TOTAL_W + SIDE_W;
	localparam int TOFF_W   = TILE_W + SIDE_W;
	localparam int ROWOFF_W = QUOT_W + IMGW_W;
	localparam int SUM_W    = ROWOFF_W + 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_READ = 2'd3;

	logic [TEXEL_W-1:0] mem [2**ADDR_W];

	logic [1:0]          state_q;
	logic [SIDE_W-1:0]   tile_side_q;
	logic [TOTAL_W-1:0]  tile_total_q;
	logic                done_q;
	logic                err_q;
	logic [TEXEL_W-1:0]  rd_q;

	logic [TILE_W-1:0]   tile_q;
	logic [COL_W-1:0]    col_q;
	logic [ROW_W-1:0]    orow_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [IMGW_W-1:0]   img_w_q;
	logic [TOFF_W-1:0]   tile_off_q;
	logic [ROWOFF_W-1:0] row_off_q;

	logic                  accept;
	logic                  bad;
	logic                  wr_en;
	logic                  rd_en;
	logic                  div_start;
	logic [DIVIDEND_W-1:0] dividend;
	logic [SUM_W-1:0]      addr_sum;
	logic [ADDR_W-1:0]     rd_addr;
	div_res_t              div_res;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign wr_en  = accept && (mode == MODE_WRITE);
	assign rd_en  = (state_q == ST_READ);

	// source row >= tile_side exactly when output_row >= scaled_height
	assign bad = (tile_side_q == '0) || (tile_side_q > MAX_SIDE_V)
		|| (tile_total_q == '0) || (tile_total_q > MAX_TOTAL_V)
		|| (scaled_height == '0) || (scaled_height > MAX_HEIGHT_V)
		|| ({1'b0, tile_number} >= tile_total_q)
		|| ({1'b0, tile_column} >= tile_side_q)
		|| ({1'b0, output_row} >= scaled_height);

	assign div_start = (state_q == ST_MUL);
	assign dividend  = DIVIDEND_W'(orow_q) * DIVIDEND_W'(tile_side_q);

	assign addr_sum = SUM_W'(row_off_q) + SUM_W'(tile_off_q) + SUM_W'(col_q);
	assign rd_addr  = addr_sum[ADDR_W-1:0];

	tcs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (height_q),
		.res      (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_side_q  <= TILE_SIDE_RESET;
			tile_total_q <= TILE_TOTAL_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_TILE_SIDE:  tile_side_q  <= cfg_data;
				REG_TILE_TOTAL: tile_total_q <= cfg_data[TOTAL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			err_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && (mode == MODE_SAMPLE)) begin
						if (bad) begin
							done_q <= 1'b1;
							err_q  <= 1'b1;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_res.done) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					done_q  <= 1'b1;
					err_q   <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tile_q   <= tile_number;
			col_q    <= tile_column;
			orow_q   <= output_row;
			height_q <= scaled_height;
		end
		if (state_q == ST_MUL) begin
			img_w_q    <= IMGW_W'(tile_total_q) * IMGW_W'(tile_side_q);
			tile_off_q <= TOFF_W'(tile_q) * TOFF_W'(tile_side_q);
		end
		if ((state_q == ST_DIV) && div_res.done) begin
			row_off_q <= ROWOFF_W'(div_res.quotient) * ROWOFF_W'(img_w_q);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[store_address] <= store_value;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign done        = done_q;
	assign range_error = err_q;
	assign texel       = err_q ? '0 : rd_q;

	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == ST_READ)
			|| ($past(start) && !$past(busy) && ($past(mode) == MODE_SAMPLE)))
		else $error("result beat without a sample behind it");

	a_div_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> (state_q == ST_DIV))
		else $error("divider finished outside its wait state");

	a_write_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (mode == MODE_WRITE)) |=> !busy && !done)
		else $error("texel write left the block busy or gave a result");

endmodule
`default_nettype wire

// ===== hdl/tcs_div.sv =====
// bit-serial restoring divider for the source row, one quotient bit a cycle
`default_nettype none
module tcs_div (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [tcs_pkg::DIVIDEND_W-1:0] dividend,
	input  wire logic [tcs_pkg::HEIGHT_W-1:0]   divisor,
	output tcs_pkg::div_res_t                   res
);
	import tcs_pkg::*;

	logic                  running_q;
	logic                  done_q;
	logic [CNT_W-1:0]      count_q;
	logic [DIVIDEND_W-1:0] rem_q;
	logic [DIVIDEND_W-1:0] dsh_q;
	logic [QUOT_W-1:0]     quot_q;
	logic [DIVIDEND_W:0]   diff;
	logic                  fits;

	assign diff = {1'b0, rem_q} - {1'b0, dsh_q};
	assign fits = ~diff[DIVIDEND_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			done_q    <= 1'b0;
			count_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				running_q <= 1'b1;
				count_q   <= CNT_W'(QUOT_W - 1);
			end else if (running_q) begin
				if (count_q == '0) begin
					running_q <= 1'b0;
					done_q    <= 1'b1;
				end else begin
					count_q <= count_q - CNT_W'(1);
				end
			end
		end
	end

	// quotient is known to stay below 2^QUOT_W, so start with the divisor at the top bit
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= dividend;
			dsh_q  <= DIVIDEND_W'(divisor) << (QUOT_W - 1);
			quot_q <= '0;
		end else if (running_q) begin
			if (fits) begin
				rem_q <= diff[DIVIDEND_W-1:0];
			end
			dsh_q  <= dsh_q >> 1;
			quot_q <= {quot_q[QUOT_W-2:0], fits};
		end
	end

	assign res.done     = done_q;
	assign res.quotient = quot_q;

endmodule
`default_nettype wire
